>>> src/olmtf_pkg.sv
// ----------------------------------------------------------------------------
// olmtf_pkg
// Shared widths, request and status codes, and the controller/datapath
// command and status bundles of the ordered list block.
// ----------------------------------------------------------------------------
package olmtf_pkg;

    localparam int REQ_W     = 2;
    localparam int POS_W     = 5;
    localparam int KEY_W     = 32;
    localparam int STAT_W    = 2;
    localparam int FPOS_W    = 4;
    localparam int TOTAL_W   = 5;
    localparam int S_TDATA_W = 40;  // position + key, padded to bytes
    localparam int M_TDATA_W = 48;  // found position + read value + total

    // request kinds
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

    // datapath -> controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             ins_range;   // insert position past the end
        logic             full;
        logic             rd_range;    // read position past the end
        logic             scan_more;   // entries left to read in a search
        logic             hit;         // pending read matches the key
        logic             shift_more;  // entries left to move
        logic             pend;        // a read word is in flight
        logic             out_free;    // output register can take a result
    } t_dp_status;

    // controller -> datapath
    typedef struct packed {
        logic              cap;         // take the request in
        logic              scan_rd;     // read next entry of a search
        logic              mark_hit;    // note the hit, set up the move to front
        logic              shift_start; // set up the insert shift
        logic              shift_rd;    // read next entry to move
        logic              shift_wr;    // write moved entry one place back
        logic              put;         // write the key at the low end
        logic              pos_rd;      // read entry at the request position
        logic              load_out;    // load the result register
        logic [STAT_W-1:0] code;
    } t_dp_cmd;

endpackage

>>> src/olmtf_ctrl.sv
// ----------------------------------------------------------------------------
// olmtf_ctrl
// Request sequencer: decides each request, runs the search scan, the
// entry shift and the final write, and hands the result to the output.
// ----------------------------------------------------------------------------
module olmtf_ctrl import olmtf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [STAT_W-1:0] r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        o_cmd      = '0;
        o_cmd.code = r_code;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                case (i_status.req)
                    REQ_INSERT: begin
                        if (i_status.ins_range) begin
                            n_code  = ST_RANGE;
                            n_state = S_DONE;
                        end else if (i_status.full) begin
                            n_code  = ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.shift_start = 1'b1;
                            n_code            = ST_OK;
                            n_state           = S_SHIFT;
                        end
                    end
                    REQ_SEARCH: begin
                        n_state = S_SCAN;
                    end
                    REQ_READ: begin
                        if (i_status.rd_range) begin
                            n_code  = ST_RANGE;
                            n_state = S_DONE;
                        end else begin
                            // read word is registered by the time DONE is reached
                            o_cmd.pos_rd = 1'b1;
                            n_code       = ST_OK;
                            n_state      = S_DONE;
                        end
                    end
                    default: begin
                        n_code  = ST_RANGE;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_status.hit) begin
                    o_cmd.mark_hit = 1'b1;
                    n_code         = ST_OK;
                    n_state        = S_SHIFT;
                end else if (i_status.scan_more) begin
                    o_cmd.scan_rd = 1'b1;
                end else if (!i_status.pend) begin
                    n_code  = ST_MISS;
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_rd = i_status.shift_more;
                o_cmd.shift_wr = i_status.pend;
                if (!i_status.shift_more && !i_status.pend) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/olmtf_dp.sv
// ----------------------------------------------------------------------------
// olmtf_dp
// List memory, entry count, scan/shift address counters and the result
// register.
// ----------------------------------------------------------------------------
module olmtf_dp import olmtf_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic [REQ_W-1:0]   i_req,
    input  logic [POS_W-1:0]   i_pos,
    input  logic [KEY_W-1:0]   i_key,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [STAT_W-1:0]  o_out_status,
    output logic [FPOS_W-1:0]  o_out_fpos,
    output logic [KEY_W-1:0]   o_out_rval,
    output logic [TOTAL_W-1:0] o_out_total
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int HW   = (AW > FPOS_W) ? AW : FPOS_W;
    localparam int TW   = (CW > TOTAL_W) ? CW : TOTAL_W;

    logic [KEY_W-1:0]   mem [DEPTH];

    logic [REQ_W-1:0]   r_req;
    logic [POS_W-1:0]   r_pos;
    logic [KEY_W-1:0]   r_key;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_left;
    logic [AW-1:0]      r_lo;
    logic [AW-1:0]      r_hit;
    logic               r_pend;
    logic [AW-1:0]      r_pend_addr;
    logic [KEY_W-1:0]   r_rdata;
    logic               r_ovalid;
    logic [STAT_W-1:0]  r_ostat;
    logic [FPOS_W-1:0]  r_ofpos;
    logic [KEY_W-1:0]   r_orval;
    logic [TOTAL_W-1:0] r_ototal;

    logic [CMPW-1:0]    w_pos_ext;
    logic [CMPW-1:0]    w_cnt_ext;
    logic [CMPW-1:0]    w_ins_left;
    logic [HW-1:0]      w_hit_ext;
    logic [TW-1:0]      w_cnt_tot;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [KEY_W-1:0]   w_wdata;

    assign w_pos_ext  = CMPW'(r_pos);
    assign w_cnt_ext  = CMPW'(r_cnt);
    assign w_ins_left = w_cnt_ext - w_pos_ext;
    assign w_hit_ext  = HW'(r_hit);
    assign w_cnt_tot  = TW'(r_cnt);

    assign o_status.req        = r_req;
    assign o_status.ins_range  = (w_pos_ext > w_cnt_ext);
    assign o_status.full       = (r_cnt == CW'(DEPTH));
    assign o_status.rd_range   = (w_pos_ext >= w_cnt_ext);
    assign o_status.scan_more  = (r_idx < r_cnt);
    assign o_status.hit        = r_pend && (r_rdata == r_key);
    assign o_status.shift_more = (r_left != '0);
    assign o_status.pend       = r_pend;
    assign o_status.out_free   = !r_ovalid || i_out_ready;

    // one read and one write port; shift reads idx while writing idx+2
    assign w_re    = i_cmd.scan_rd || i_cmd.shift_rd || i_cmd.pos_rd;
    assign w_raddr = i_cmd.pos_rd ? w_pos_ext[AW-1:0] : r_idx[AW-1:0];
    assign w_we    = i_cmd.shift_wr || i_cmd.put;
    assign w_waddr = i_cmd.put ? r_lo : (r_pend_addr + AW'(1));
    assign w_wdata = i_cmd.put ? r_key : r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // request capture and address counters
    always_ff @(posedge i_clk) begin
        r_pend_addr <= w_raddr;
        if (i_cmd.cap) begin
            r_req <= i_req;
            r_pos <= i_pos;
            r_key <= i_key;
        end
        if (i_cmd.cap) begin
            r_idx <= '0;
        end else if (i_cmd.scan_rd) begin
            r_idx <= r_idx + CW'(1);
        end else if (i_cmd.shift_start) begin
            r_idx <= r_cnt - CW'(1);
        end else if (i_cmd.mark_hit) begin
            r_idx <= CW'(r_pend_addr - AW'(1));
        end else if (i_cmd.shift_rd) begin
            r_idx <= r_idx - CW'(1);
        end
        if (i_cmd.shift_start) begin
            r_left <= w_ins_left[CW-1:0];
            r_lo   <= w_pos_ext[AW-1:0];
        end else if (i_cmd.mark_hit) begin
            r_left <= CW'(r_pend_addr);
            r_lo   <= '0;
        end else if (i_cmd.shift_rd) begin
            r_left <= r_left - CW'(1);
        end
        if (i_cmd.cap) begin
            r_hit <= '0;
        end else if (i_cmd.mark_hit) begin
            r_hit <= r_pend_addr;
        end
        if (i_cmd.load_out) begin
            r_ostat  <= i_cmd.code;
            r_ofpos  <= w_hit_ext[FPOS_W-1:0];
            r_orval  <= (r_req == REQ_READ && i_cmd.code == ST_OK) ? r_rdata : '0;
            r_ototal <= w_cnt_tot[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend <= w_re;
            if (i_cmd.put && r_req == REQ_INSERT) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_status = r_ostat;
    assign o_out_fpos   = r_ofpos;
    assign o_out_rval   = r_orval;
    assign o_out_total  = r_ototal;

endmodule

>>> src/ordered_list_insert_move_to_front.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_move_to_front
// Self-organising list of signed 32-bit values: positional insert,
// move-to-front search and positional read, one result word per request.
// ----------------------------------------------------------------------------
//
// channel  dir  tdata (low bit up)                      tuser
// s_axis   in   position[4:0], key_value[36:5]          req_type[1:0]
// m_axis   out  found_position[3:0], read_value[35:4],  status[1:0]
//               entry_total[40:36]
//
// Order: one request at a time. A read or a refused request goes straight to
// the result; an insert moves the entries from its position to the end one
// place back and then writes the key; a search reads from the front until it
// hits, moves the entries before the hit one place back and writes the key at
// the front, or reports a miss; the memory reads and moves one entry a cycle.
// Reset: i_rst_n, synchronous, active low; empties the list at once.
// Stalls: a finished word sits in the output register while the next
// request is taken; the sequencer waits only if that register is still full.
//
module ordered_list_insert_move_to_front import olmtf_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // position, key_value
    input  logic [REQ_W-1:0]     s_axis_tuser,   // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // found_position, read_value, entry_total
    output logic [STAT_W-1:0]    m_axis_tuser    // status
);

    t_dp_cmd            w_cmd;
    t_dp_status         w_stat;
    logic [FPOS_W-1:0]  w_fpos;
    logic [KEY_W-1:0]   w_rval;
    logic [TOTAL_W-1:0] w_total;

    // sequencer
    olmtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_stat),
        .o_cmd      (w_cmd)
    );

    // list storage and result register
    olmtf_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_stat),
        .i_req        (s_axis_tuser),
        .i_pos        (s_axis_tdata[POS_W-1:0]),
        .i_key        (s_axis_tdata[POS_W+KEY_W-1:POS_W]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_fpos   (w_fpos),
        .o_out_rval   (w_rval),
        .o_out_total  (w_total)
    );

    assign m_axis_tdata = {{(M_TDATA_W - FPOS_W - KEY_W - TOTAL_W){1'b0}},
                           w_total, w_rval, w_fpos};

    // one request in flight: ready drops after every accepted word
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted while one is in flight");

    // shift write and key write share the memory write port
    a_wr_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.put && w_cmd.shift_wr))
        else $error("write port conflict");

    // never overwrite a result that has not been taken
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_stat.out_free)
        else $error("result register overwritten");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_MISS) |-> (w_fpos == '0))
        else $error("miss carries a found position");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered list block: a predictor of its own keeps
// the list and its count, each accepted request word queues one expected
// result word, and every result word leaving the block is checked field by
// field against the oldest one queued. Directed checks on the empty and the
// full list come first, then random traffic on both sides, a long output
// stall that backs the block up and a stretch with no gaps.
// ----------------------------------------------------------------------------
module tb_top;
    import olmtf_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int IDLE_PCT   = 17;     // per-cycle chance of a gap, either side
    localparam int TAIL_WAIT  = 60;     // longest search plus margin
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MIN    = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX    = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FPOS_W-1:0]  found_pos;
        logic [KEY_W-1:0]   read_val;
        logic [TOTAL_W-1:0] total;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;    // position, key_value
    logic [REQ_W-1:0]     s_axis_tuser = '0;    // req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // found_position, read_value, entry_total
    logic [STAT_W-1:0]    m_axis_tuser;         // status

    // predicted list contents and occupancy
    logic [KEY_W-1:0] list_model [LIST_DEPTH];
    int unsigned      list_count;

    t_result pending_results [$];
    t_result oldest;
    int      mismatch_count = 0;
    bit      no_gaps = 1'b0;            // both sides run flat out while set
    int      sink_hold_cycles = 0;      // output held off for this many cycles

    ordered_list_insert_move_to_front #(.DEPTH(LIST_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // Run the request against the predicted list and return the word the
    // block should answer with. Updates the predicted list as a side effect.
    function automatic t_result list_predict(input logic [REQ_W-1:0] req,
                                             input logic [POS_W-1:0] pos,
                                             input logic [KEY_W-1:0] key);
        t_result r;
        int      hit;
        int      i;
        r   = '0;
        hit = -1;
        case (req)
            REQ_INSERT: begin
                // position test ranks above the full test
                if (pos > list_count) begin
                    r.status = ST_RANGE;
                end else if (list_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_count; i > pos; i--)
                        list_model[i] = list_model[i-1];
                    list_model[pos] = key;
                    list_count++;
                    r.status = ST_OK;
                end
            end
            REQ_SEARCH: begin
                for (i = 0; i < list_count; i++)
                    if (hit < 0 && list_model[i] == key)
                        hit = i;
                if (hit < 0) begin
                    r.status = ST_MISS;
                end else begin
                    // hit moves to the front, the rest keep their order
                    for (i = hit; i > 0; i--)
                        list_model[i] = list_model[i-1];
                    list_model[0] = key;
                    r.status    = ST_OK;
                    r.found_pos = hit[FPOS_W-1:0];
                end
            end
            REQ_READ: begin
                if (pos >= list_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.status   = ST_OK;
                    r.read_val = list_model[pos];
                end
            end
            default: r.status = ST_RANGE;   // unused request kind
        endcase
        r.total = list_count[TOTAL_W-1:0];
        return r;
    endfunction

    // Offer one request word; returns once it has been taken.
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [POS_W-1:0] pos,
                                input logic [KEY_W-1:0] key);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {3'b000, key, pos};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(list_predict(req, pos, key));
    endtask

    // ---- output side: ready pattern, with an optional long hold-off ----
    always @(negedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            m_axis_tready    = 1'b0;
            sink_hold_cycles = sink_hold_cycles - 1;
        end else begin
            m_axis_tready = no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic void check_field(input string name, input longint want_v,
                                        input longint got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // ---- result checker ----
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no request outstanding");
                mismatch_count++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("status", longint'(oldest.status), longint'(m_axis_tuser));
                check_field("found_position", longint'(oldest.found_pos),
                            longint'(m_axis_tdata[3:0]));
                check_field("read_value", longint'($signed(oldest.read_val)),
                            longint'($signed(m_axis_tdata[35:4])));
                check_field("entry_total", longint'(oldest.total),
                            longint'(m_axis_tdata[40:36]));
            end
        end
    end

    // ---- tests ----

    // Every kind of request against an empty list, plus the unused kind.
    task automatic test_empty_list();
        send_request(REQ_READ,   5'd0,  32'h1234_5678);
        send_request(REQ_SEARCH, 5'd0,  32'h0000_0000);
        send_request(REQ_INSERT, 5'd1,  KEY_MAX);       // past the end
        send_request(REQ_UNUSED, 5'd31, 32'hFFFF_FFFF);
        send_request(REQ_READ,   5'd31, 32'h0);
    endtask

    // Fill to the brim: ends, front and middle inserts, extreme keys and a
    // duplicate so that a search has to take the first match.
    task automatic test_fill_list();
        logic [POS_W-1:0] p;
        send_request(REQ_INSERT, 5'd0, KEY_MIN);
        send_request(REQ_INSERT, 5'd1, KEY_MAX);
        send_request(REQ_INSERT, 5'd0, 32'h0000_0000);  // front
        send_request(REQ_INSERT, 5'd1, 32'hFFFF_FFFF);  // middle
        send_request(REQ_INSERT, 5'd4, 32'h5555_5555);
        send_request(REQ_INSERT, 5'd2, 32'hAAAA_AAAA);
        send_request(REQ_INSERT, 5'd6, 32'h0000_0000);  // duplicate
        while (list_count < LIST_DEPTH) begin
            p = POS_W'($urandom_range(list_count));
            send_request(REQ_INSERT, p, $urandom());
        end
    endtask

    // Full list: full flag, position test first, reads at and past the end.
    task automatic test_full_list();
        send_request(REQ_INSERT, 5'd16, 32'h0BAD_0BAD);
        send_request(REQ_INSERT, 5'd17, 32'h0BAD_0BAD);
        send_request(REQ_INSERT, 5'd0,  32'h0BAD_0BAD);
        send_request(REQ_READ,   5'd15, 32'h0);
        send_request(REQ_READ,   5'd16, 32'h0);
    endtask

    // Hit at the front, hit at the back, first of two equal keys, a miss.
    task automatic test_move_to_front();
        logic [KEY_W-1:0] absent;
        send_request(REQ_SEARCH, 5'd0, list_model[0]);
        send_request(REQ_SEARCH, 5'd0, list_model[LIST_DEPTH-1]);
        send_request(REQ_SEARCH, 5'd0, 32'h0000_0000);
        absent = $urandom();
        while (absent inside {list_model})
            absent = $urandom();
        send_request(REQ_SEARCH, 5'd0, absent);
    endtask

    // Mostly searches for keys held in the list and reads in range, with
    // refused inserts, stray positions, missing keys and the unused kind.
    task automatic test_random_mix(input int count);
        int               sel;
        logic [REQ_W-1:0] req;
        logic [POS_W-1:0] pos;
        logic [KEY_W-1:0] key;
        repeat (count) begin
            sel = $urandom_range(99);
            key = $urandom();
            pos = POS_W'($urandom());
            if (sel < 45) begin
                req = REQ_SEARCH;
                if (list_count > 0 && $urandom_range(9) < 8)
                    key = list_model[$urandom_range(list_count - 1)];
            end else if (sel < 75) begin
                req = REQ_READ;
                if (list_count > 0 && $urandom_range(9) < 8)
                    pos = POS_W'($urandom_range(list_count - 1));
            end else if (sel < 95) begin
                req = REQ_INSERT;
                if ($urandom_range(1))
                    pos = POS_W'($urandom_range(list_count + 1));
                if ($urandom_range(9) == 0)
                    key = $urandom_range(1) ? KEY_MIN : KEY_MAX;
            end else begin
                req = REQ_UNUSED;
            end
            send_request(req, pos, key);
        end
    endtask

    // Both sides flat out.
    task automatic test_back_to_back();
        no_gaps = 1'b1;
        test_random_mix(100);
        no_gaps = 1'b0;
    endtask

    // Output held off long enough for the block to stop taking requests.
    task automatic test_output_stall();
        sink_hold_cycles = 200;
        test_random_mix(20);
    endtask

    initial begin
        list_count = 0;
        foreach (list_model[i])
            list_model[i] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_fill_list();
        test_full_list();
        test_move_to_front();
        test_random_mix(300);
        test_output_stall();
        test_back_to_back();
        test_random_mix(350);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog: well beyond the slowest legal run
    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/olmtf_pkg.sv
src/olmtf_ctrl.sv
src/olmtf_dp.sv
src/ordered_list_insert_move_to_front.sv
test/tb_top.sv
